// ===== design/srd_pkg.sv =====
// Shared types and constants for the stable reading detector.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package srd_pkg;

    // Defaults for the top-level parameters
    localparam int WINDOW_LEN_DEF   = 5;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Band register
    localparam int              BAND_W     = 15;
    localparam logic [BAND_W-1:0] BAND_RESET = 15'd16;

    // Consecutive misses that restart the window
    localparam int MISS_W     = 2;
    localparam int MISS_LIMIT = 3;

    // Quotient bits resolved per divider cycle
    localparam int DIV_STEP_BITS = 4;

    // Configuration bus
    localparam int   APB_ADDR_W   = 3;
    localparam int   APB_DATA_W   = 32;
    localparam logic REG_IDX_BAND = 1'b0;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_START,
        ST_DIVIDE,
        ST_DONE
    } srd_state_t;

    // Window update request
    typedef struct packed {
        logic push;
        logic reseed;
    } srd_win_cmd_t;

endpackage

`default_nettype wire

// ===== design/srd_window.sv =====
// Sample window: entries, fill count, write slot and running sum.
// Depends on srd_pkg for the update command struct.
`default_nettype none

module srd_window #(
    parameter int WINDOW_LEN   = srd_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_WIDTH = srd_pkg::SAMPLE_WIDTH_DEF,
    localparam int SUM_W = SAMPLE_WIDTH + $clog2(WINDOW_LEN),
    localparam int CNT_W = $clog2(WINDOW_LEN + 1)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire srd_pkg::srd_win_cmd_t          cmd,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic signed [SUM_W-1:0]             sum,
    output logic [CNT_W-1:0]                    fill
);

    localparam int IDX_W = $clog2(WINDOW_LEN);

    logic signed [SAMPLE_WIDTH-1:0] entry_reg [WINDOW_LEN];
    logic signed [SUM_W-1:0]        sum_reg;
    logic signed [SUM_W-1:0]        sum_next;
    logic [CNT_W-1:0]               fill_reg;
    logic [CNT_W-1:0]               fill_next;
    logic [IDX_W-1:0]               slot_reg;
    logic [IDX_W-1:0]               slot_next;
    logic signed [SAMPLE_WIDTH-1:0] old_entry;
    logic signed [SUM_W-1:0]        sample_ext;
    logic signed [SUM_W-1:0]        old_ext;

    // Entry that the new sample replaces
    assign old_entry  = entry_reg[slot_reg];
    assign sample_ext = SUM_W'(sample);
    assign old_ext    = SUM_W'(old_entry);

    // Next sum, fill and slot
    always_comb
    begin
        sum_next  = sum_reg;
        fill_next = fill_reg;
        slot_next = slot_reg;
        if (cmd.reseed)
        begin
            sum_next  = sample_ext;
            fill_next = CNT_W'(1);
            slot_next = IDX_W'(1);
        end
        else if (cmd.push)
        begin
            sum_next = sum_reg + sample_ext - old_ext;
            if (fill_reg != CNT_W'(WINDOW_LEN))
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
            if (slot_reg == IDX_W'(WINDOW_LEN - 1))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + IDX_W'(1);
            end
        end
    end

    // Hold the window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                entry_reg[i] <= '0;
            end
            sum_reg  <= '0;
            fill_reg <= '0;
            slot_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                if (cmd.reseed)
                begin
                    entry_reg[i] <= (i == 0) ? sample : '0;
                end
                else if (cmd.push && (slot_reg == IDX_W'(i)))
                begin
                    entry_reg[i] <= sample;
                end
            end
            sum_reg  <= sum_next;
            fill_reg <= fill_next;
            slot_reg <= slot_next;
        end
    end

    assign sum  = sum_reg;
    assign fill = fill_reg;

endmodule

`default_nettype wire

// ===== design/srd_divider.sv =====
// Iterative signed divider: window sum over fill count, truncated toward zero.
// Resolves srd_pkg::DIV_STEP_BITS quotient bits per cycle with one narrow subtractor chain.
`default_nettype none

module srd_divider #(
    parameter int WINDOW_LEN   = srd_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_WIDTH = srd_pkg::SAMPLE_WIDTH_DEF,
    localparam int SUM_W = SAMPLE_WIDTH + $clog2(WINDOW_LEN),
    localparam int CNT_W = $clog2(WINDOW_LEN + 1)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [SUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0]        divisor,
    output logic                         done,
    output logic signed [SAMPLE_WIDTH-1:0] quotient
);

    localparam int STEP_BITS = srd_pkg::DIV_STEP_BITS;
    localparam int DIV_W     = ((SUM_W + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int STEPS     = DIV_W / STEP_BITS;
    localparam int STEP_CW   = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [DIV_W-1:0]   work_reg;
    logic [DIV_W-1:0]   work_next;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   rem_next;
    logic [CNT_W-1:0]   div_reg;
    logic               neg_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [STEP_CW-1:0] step_reg;
    logic [SUM_W-1:0]   dvd_u;
    logic [SUM_W-1:0]   mag;
    logic [SUM_W-1:0]   q_mag;
    logic [SUM_W-1:0]   q_signed;
    logic [CNT_W:0]     trial;

    // Magnitude of the dividend
    assign dvd_u = dividend;
    assign mag   = dvd_u[SUM_W-1] ? (~dvd_u + SUM_W'(1)) : dvd_u;

    // One step of restoring division: shift dividend bits into the remainder, quotient bits into the work register
    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        trial     = '0;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            trial     = {rem_next, work_next[DIV_W-1]};
            work_next = {work_next[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                trial        = trial - {1'b0, div_reg};
                work_next[0] = 1'b1;
            end
            rem_next = trial[CNT_W-1:0];
        end
    end

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_CW'(1);
                if (step_reg == STEP_CW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= DIV_W'(mag);
            rem_reg  <= '0;
            div_reg  <= divisor;
            neg_reg  <= dvd_u[SUM_W-1];
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    // Restore the sign; the average always fits the sample width
    assign q_mag    = work_reg[SUM_W-1:0];
    assign q_signed = neg_reg ? (~q_mag + SUM_W'(1)) : q_mag;
    assign quotient = q_signed[SAMPLE_WIDTH-1:0];
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== design/stable_reading_detector.sv =====
// Stable reading detector: band check, miss counting and running average sequencer.
// Depends on srd_pkg, srd_window and srd_divider.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata, one signed sample each.
//   Every input item yields exactly one result item on m_tvalid/m_tready with
//   the running average in m_tdata and the stable flag in m_tuser.
//   band_width is written over the APB port at byte address 0; the user must
//   do so only while idle, as the block itself does not enforce it. A sample
//   inside the band passes through the check, the start and the divider, which
//   resolves four quotient bits per cycle, then the result load; a sample
//   outside the band goes from the check straight to the result load.
//   The result appears in the output register at the same edge at which
//   s_tready returns high. The output register holds a result until it is taken;
//   while it is stalled the block still accepts and works on the next item
//   and waits only when that item's result is ready to load.
//   Reset clears the window, fill count, average, slot and miss count and
//   sets band_width to 16; no result is pending after reset.
`default_nettype none

module stable_reading_detector #(
    parameter int WINDOW_LEN   = srd_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_WIDTH = srd_pkg::SAMPLE_WIDTH_DEF,
    localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [DATA_W-1:0]               s_tdata,   // [SAMPLE_WIDTH-1:0] sample
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [DATA_W-1:0]                    m_tdata,   // [SAMPLE_WIDTH-1:0] average
    output logic                                 m_tuser,   // [0] stable
    // Configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [srd_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [srd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [srd_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int SUM_W  = SAMPLE_WIDTH + $clog2(WINDOW_LEN);
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int BAND_W = srd_pkg::BAND_W;
    localparam int MISS_W = srd_pkg::MISS_W;
    localparam int CMP_W  = ((SAMPLE_WIDTH > BAND_W) ? SAMPLE_WIDTH : BAND_W) + 2;

    srd_pkg::srd_state_t            state_reg;
    srd_pkg::srd_state_t            state_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] avg_reg;
    logic signed [SAMPLE_WIDTH-1:0] avg_next;
    logic                           stable_reg;
    logic                           stable_next;
    logic [MISS_W-1:0]              miss_reg;
    logic [MISS_W-1:0]              miss_next;
    logic [BAND_W-1:0]              band_reg;
    logic                           m_tvalid_reg;
    logic                           m_tvalid_next;
    logic [DATA_W-1:0]              m_tdata_reg;
    logic                           m_tuser_reg;
    logic                           load_out;
    logic                           in_accept;
    logic                           cfg_write;
    logic                           div_start;
    logic                           div_done;
    logic signed [SAMPLE_WIDTH-1:0] div_quotient;
    logic signed [SUM_W-1:0]        win_sum;
    logic [CNT_W-1:0]               win_fill;
    srd_pkg::srd_win_cmd_t          win_cmd;
    logic signed [CMP_W-1:0]        sample_ext;
    logic signed [CMP_W-1:0]        avg_ext;
    logic signed [CMP_W-1:0]        band_ext;
    logic signed [CMP_W-1:0]        upper;
    logic signed [CMP_W-1:0]        lower;
    logic                           in_band;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == srd_pkg::REG_IDX_BAND);
    assign prdata    = (paddr[2] == srd_pkg::REG_IDX_BAND)
                       ? {{(srd_pkg::APB_DATA_W - BAND_W){1'b0}}, band_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg <= srd_pkg::BAND_RESET;
        end
        else if (cfg_write)
        begin
            band_reg <= pwdata[BAND_W-1:0];
        end
    end

    // Band check: strictly inside (avg - band, avg + band)
    assign sample_ext = CMP_W'(sample_reg);
    assign avg_ext    = CMP_W'(avg_reg);
    assign band_ext   = $signed({{(CMP_W - BAND_W){1'b0}}, band_reg});
    assign upper      = avg_ext + band_ext;
    assign lower      = avg_ext - band_ext;
    assign in_band    = (sample_ext < upper) && (sample_ext > lower);

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == srd_pkg::ST_IDLE);
    assign load_out  = (state_reg == srd_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        avg_next       = avg_reg;
        stable_next    = stable_reg;
        miss_next      = miss_reg;
        win_cmd.push   = 1'b0;
        win_cmd.reseed = 1'b0;
        div_start      = 1'b0;
        case (state_reg)
            srd_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = srd_pkg::ST_CHECK;
                end
            end
            srd_pkg::ST_CHECK:
            begin
                if (in_band)
                begin
                    win_cmd.push = 1'b1;
                    stable_next  = (win_fill > CNT_W'(1));
                    miss_next    = '0;
                    state_next   = srd_pkg::ST_START;
                end
                else
                begin
                    stable_next = 1'b0;
                    state_next  = srd_pkg::ST_DONE;
                    if (miss_reg == MISS_W'(srd_pkg::MISS_LIMIT - 1))
                    begin
                        win_cmd.reseed = 1'b1;
                        avg_next       = sample_reg;
                        miss_next      = '0;
                    end
                    else
                    begin
                        miss_next = miss_reg + MISS_W'(1);
                    end
                end
            end
            srd_pkg::ST_START:
            begin
                div_start  = 1'b1;
                state_next = srd_pkg::ST_DIVIDE;
            end
            srd_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    avg_next   = div_quotient;
                    state_next = srd_pkg::ST_DONE;
                end
            end
            srd_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = srd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srd_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= srd_pkg::ST_IDLE;
            avg_reg      <= '0;
            stable_reg   <= 1'b0;
            miss_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            avg_reg      <= avg_next;
            stable_reg   <= stable_next;
            miss_reg     <= miss_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= s_tdata[SAMPLE_WIDTH-1:0];
        end
        if (load_out)
        begin
            m_tdata_reg <= DATA_W'($unsigned(avg_reg));
            m_tuser_reg <= stable_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Window store
    srd_window #(
        .WINDOW_LEN   (WINDOW_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (win_cmd),
        .sample (sample_reg),
        .sum    (win_sum),
        .fill   (win_fill)
    );

    // Iterative divider
    srd_divider #(
        .WINDOW_LEN   (WINDOW_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (win_sum),
        .divisor  (win_fill),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_tready)
        else $error("input accepted again while an item is in progress");

    a_miss_bound: assert property (@(posedge clk) disable iff (!rst_n)
        miss_reg <= MISS_W'(srd_pkg::MISS_LIMIT - 1))
        else $error("miss count passed the restart limit");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        win_fill <= CNT_W'(WINDOW_LEN))
        else $error("fill count beyond window length");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == srd_pkg::ST_DIVIDE))
        else $error("divider finished outside the divide state");

endmodule

`default_nettype wire

// ===== test/srd_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the stable reading detector: watches the APB port and both streams,
// predicts each result from its own copy of the detector state and compares.
// Depends on srd_pkg for widths, the band register index and reset values.

module srd_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [15:0]                        s_tdata,   // [15:0] sample
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [15:0]                        m_tdata,   // [15:0] average
    input  logic                               m_tuser,   // [0] stable
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [srd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [srd_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic [srd_pkg::APB_DATA_W-1:0]     prdata,
    input  logic                               pready,
    output int                                 errors,
    output int                                 outstanding
);
    import srd_pkg::*;

    localparam int WLEN = WINDOW_LEN_DEF;

    typedef struct packed {
        logic        stable;
        logic [15:0] average;
    } reading_t;

    // Shadow of the detector state
    int               win [WLEN];
    int               fill;
    int               avg;
    int               slot;
    int               misses;
    logic [BAND_W-1:0] band;

    reading_t pending_readings [$];

    initial errors = 0;
    initial outstanding = 0;

    // Apply one sample to the shadow state and return the reading it yields
    function automatic reading_t predict_reading(input logic signed [15:0] sample);
        reading_t r;
        int       s;
        int       b;
        int       sum;
        s = sample;
        b = band;
        r.stable = 1'b0;
        if (s < avg + b && s > avg - b)
        begin
            r.stable = (fill > 1);
            if (fill < WLEN)
                fill++;
            win[slot] = s;
            sum = 0;
            for (int j = 0; j < WLEN; j++)
                sum += win[j];
            avg = sum / fill;
            slot = (slot + 1) % WLEN;
            misses = 0;
        end
        else
        begin
            misses++;
            // restart the window from this sample on the last allowed miss
            if (misses >= MISS_LIMIT)
            begin
                foreach (win[j])
                    win[j] = 0;
                win[0] = s;
                fill = 1;
                avg = s;
                slot = 1 % WLEN;
                misses = 0;
            end
        end
        r.average = avg[15:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            foreach (win[j])
                win[j] = 0;
            fill = 0;
            avg = 0;
            slot = 0;
            misses = 0;
            band = BAND_RESET;
            pending_readings.delete();
            outstanding = 0;
        end
        else
        begin
            // Track register writes, check register reads
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_IDX_BAND)
                        band = pwdata[BAND_W-1:0];
                end
                else if (paddr[2] == REG_IDX_BAND &&
                         prdata !== {{(APB_DATA_W-BAND_W){1'b0}}, band})
                begin
                    errors++;
                    $display("%0t: band readback expected %0d got %0d", $time, band, prdata);
                end
            end

            // Compare a delivered item with the oldest predicted reading
            if (m_tvalid && m_tready)
            begin
                if (pending_readings.size() == 0)
                begin
                    errors++;
                    $display("%0t: result expected none got average %0d stable %0b",
                             $time, $signed(m_tdata), m_tuser);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (m_tdata !== want.average)
                    begin
                        errors++;
                        $display("%0t: average expected %0d got %0d", $time,
                                 $signed(want.average), $signed(m_tdata));
                    end
                    if (m_tuser !== want.stable)
                    begin
                        errors++;
                        $display("%0t: stable expected %0b got %0b", $time,
                                 want.stable, m_tuser);
                    end
                end
            end

            // Predict the reading for an accepted sample
            if (s_tvalid && s_tready)
                pending_readings.push_back(predict_reading(s_tdata));

            outstanding = pending_readings.size();
        end
    end

endmodule

// ===== test/stable_reading_detector_tb.sv =====
`timescale 1ns / 100ps
// Top-level bench for stable_reading_detector: clock, reset, APB setup, sample stimulus
// with random gaps and back-pressure, and the verdict. Depends on srd_pkg and srd_checker.

module stable_reading_detector_tb;
    import srd_pkg::*;

    localparam int                  DATA_W      = ((SAMPLE_WIDTH_DEF + 7) / 8) * 8;
    localparam logic [APB_ADDR_W-1:0] BAND_ADDR   = {REG_IDX_BAND, 2'b00};
    localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = 3'b100;
    localparam int                  QUIET_LIMIT = 2000;
    localparam int                  SETTLE      = 12;
    localparam int                  PHASES      = 6;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;    // [15:0] sample
    logic                  m_tvalid;
    logic                  m_tready;
    logic [DATA_W-1:0]     m_tdata;    // [15:0] average
    logic                  m_tuser;    // [0] stable
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int   errors;
    int   outstanding;
    int   quiet;
    bit   calm;
    bit   sample_taken;
    int   cur_band;

    stable_reading_detector dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    srd_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Note whether the sample on the bus was taken at this edge
    always @(posedge clk)
        sample_taken <= s_tvalid && s_tready;

    // Random back-pressure on the result side, none while calm
    always @(negedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= 24);

    // Abort when nothing has moved for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("stable_reading_detector_tb NOT OK");
            $finish;
        end
    end

    // APB transfer, setup then access phase, starting and ending at a falling edge
    task automatic apb_xfer(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drop the input, then hold off until every reading is back and the block is idle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Change the band once the block is idle, then read it back
    task automatic set_band(input int value);
        drain();
        apb_xfer(1'b1, BAND_ADDR, value);
        apb_xfer(1'b0, BAND_ADDR, '0);
        cur_band = value;
    endtask

    // Present one sample, after a random gap unless calm, and hold it until taken
    task automatic send_sample(input int value);
        while (!calm && $urandom_range(0, 99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value[DATA_W-1:0];
        do
            @(negedge clk);
        while (!sample_taken);
    endtask

    function automatic int clamp16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Mostly settled runs around a level, some lone random samples and some runs of one or two outliers
    task automatic send_readings(input int count);
        int sent;
        int level;
        int jit;
        int run_len;
        int kind;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(0, 99);
            level = $signed(16'($urandom_range(0, 65535)));
            if (kind < 70)
            begin
                // three samples at the new level re-seed the window if they fall outside the band
                jit = (cur_band > 1) ? (cur_band - 1) / 2 : 0;
                if ($urandom_range(0, 3) == 0)
                    jit = jit / 16;
                repeat (3) send_sample(level);
                run_len = $urandom_range(3, 12);
                repeat (run_len)
                    send_sample(clamp16(level + $urandom_range(0, 2 * jit) - jit));
                sent += 3 + run_len;
            end
            else if (kind < 85)
            begin
                send_sample(level);
                sent++;
            end
            else
            begin
                run_len = $urandom_range(1, 2);
                repeat (run_len) send_sample(level ^ 32'h8000);
                sent += run_len;
            end
        end
    endtask

    initial
    begin
        int bands  [PHASES];
        int counts [PHASES];
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        quiet    = 0;
        calm     = 1'b0;
        cur_band = BAND_RESET;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset band: fill the window, hit both sample extremes and re-seed on the third miss
        send_sample(0);
        send_sample(5);
        send_sample(-3);
        send_sample(15);
        send_sample(-15);
        send_sample(16);
        send_sample(32767);
        send_sample(-32768);
        send_sample(-32768);
        send_sample(-32760);
        send_sample(-32767);
        send_sample(-32767);
        send_sample(-32767);
        send_sample(-32766);

        // Zero band rejects everything
        set_band(0);
        send_sample(100);
        send_sample(100);
        send_sample(100);
        send_sample(-1);

        // Widest band; a write past the register list must change nothing
        set_band(32767);
        apb_xfer(1'b1, UNUSED_ADDR, 32'd3);
        apb_xfer(1'b0, BAND_ADDR, '0);
        send_sample(32767);
        send_sample(-32768);
        send_sample(32767);
        send_sample(-32768);
        send_sample(0);
        send_sample(32767);

        // Random phases over several band settings
        bands  = '{$urandom_range(1, 64), 32767, 0, $urandom_range(0, 32767), 1, 300};
        counts = '{300, 250, 60, 300, 250, 340};
        for (int p = 0; p < PHASES; p++)
        begin
            set_band(bands[p]);
            calm = (p == 3);
            send_readings(counts[p] / 2);
            if (p == 0)
                drain();
            send_readings(counts[p] - counts[p] / 2);
        end
        calm = 1'b0;

        drain();
        if (errors == 0)
            $display("stable_reading_detector_tb OK");
        else
            $display("stable_reading_detector_tb NOT OK");
        $finish;
    end

endmodule

// ===== stable_reading_detector.f =====
design/srd_pkg.sv
design/srd_window.sv
design/srd_divider.sv
design/stable_reading_detector.sv
test/srd_checker.sv
test/stable_reading_detector_tb.sv
